### rtl/gsb_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`default_nettype none
package gsb_pkg;
  localparam int CAPACITY_DEF     = 64;
  localparam int TEXTURE_BITS_DEF = 16;
  localparam int IDX_W            = 6;
  localparam int TEX_PORT_W       = 16;
  localparam int DEPTH_W          = 16;
  localparam int OFFS_W           = 9;
  localparam int MODE_W           = 2;
  localparam logic [OFFS_W-1:0] VERTS_PER_GLYPH = 9'd6;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE      = 2'd0,
    MODE_DEPTH_UP  = 2'd1,
    MODE_DEPTH_DN  = 2'd2,
    MODE_TEXTURE   = 2'd3
  } sort_mode_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             clear;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             emit;
  } gsb_cmd_t;

  typedef struct packed {
    logic emit_last;
  } gsb_stat_t;
endpackage
`default_nettype wire

### rtl/gsb_ctrl.sv
// Controller state machine: load, sort feed, drain and emit sequencing.
`default_nettype none
module gsb_ctrl import gsb_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      final_glyph,
  output logic           busy,
  output gsb_cmd_t       cmd,
  input  wire gsb_stat_t stat
);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_SORT, S_DRAIN, S_EMIT} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_ptr;
  logic             room;
  logic             accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign room   = (count < CNT_W'(CAPACITY));

  always_comb begin
    cmd         = '0;
    cmd.wr_en   = accept && room;
    cmd.wr_addr = IDX_W'(count);
    cmd.clear   = accept && final_glyph;
    cmd.rd_en   = (state == S_SORT);
    cmd.rd_addr = IDX_W'(rd_ptr);
    cmd.emit    = (state == S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_ptr <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (room) count <= count + 1'b1;
            if (final_glyph) begin
              state  <= S_SORT;
              rd_ptr <= '0;
            end
          end
        end
        S_SORT: begin
          if (CNT_W'(rd_ptr + 1'b1) == count) state <= S_DRAIN;
          else rd_ptr <= rd_ptr + 1'b1;
        end
        S_DRAIN: state <= S_EMIT;
        S_EMIT: begin
          if (stat.emit_last) begin
            state <= S_IDLE;
            count <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/gsb_datapath.sv
// Datapath: record store, insertion-sort cell chain and result registers.
`default_nettype none
module gsb_datapath import gsb_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int TEXTURE_BITS = TEXTURE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [MODE_W-1:0]     cfg_data,
  input  wire logic [TEX_PORT_W-1:0] texture_id,
  input  wire logic signed [DEPTH_W-1:0] depth_key,
  input  wire gsb_cmd_t              cmd,
  output gsb_stat_t                  stat,
  output logic                       result_valid,
  output logic [IDX_W-1:0]           glyph_index,
  output logic [TEX_PORT_W-1:0]      glyph_texture,
  output logic [OFFS_W-1:0]          vertex_offset,
  output logic                       batch_start,
  output logic                       batch_end,
  output logic                       run_last
);
  sort_mode_t sort_mode;

  logic [TEXTURE_BITS-1:0]  tex_mem [CAPACITY];
  logic signed [DEPTH_W-1:0] dep_mem [CAPACITY];

  logic [TEXTURE_BITS-1:0]   ins_tex;
  logic signed [DEPTH_W-1:0] ins_dep;
  logic [IDX_W-1:0]          ins_idx;
  logic                      ins_vld;

  logic [TEXTURE_BITS-1:0]   cell_tex [CAPACITY];
  logic signed [DEPTH_W-1:0] cell_dep [CAPACITY];
  logic [IDX_W-1:0]          cell_idx [CAPACITY];
  logic [CAPACITY-1:0]       cell_vld;
  logic [CAPACITY-1:0]       take;

  logic                      first;
  logic [TEXTURE_BITS-1:0]   prev_tex;
  logic [OFFS_W-1:0]         offset;

  always_ff @(posedge clk) begin
    if (rst) sort_mode <= MODE_NONE;
    else if (cfg_we) sort_mode <= sort_mode_t'(cfg_data);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      tex_mem[cmd.wr_addr] <= TEXTURE_BITS'(texture_id);
      dep_mem[cmd.wr_addr] <= depth_key;
    end
    ins_tex <= tex_mem[cmd.rd_addr];
    ins_dep <= dep_mem[cmd.rd_addr];
    ins_idx <= cmd.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) ins_vld <= 1'b0;
    else ins_vld <= cmd.rd_en;
  end

  // A cell takes a new value when it is empty or the incoming record goes
  // strictly before it; equal keys stay behind, which keeps the sort stable.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      case (sort_mode)
        MODE_DEPTH_UP: take[i] = ins_dep < cell_dep[i];
        MODE_DEPTH_DN: take[i] = ins_dep > cell_dep[i];
        MODE_TEXTURE:  take[i] = ins_tex < cell_tex[i];
        default:       take[i] = 1'b0;
      endcase
      take[i] = take[i] || !cell_vld[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins_vld && take[i]) begin
        if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
          cell_tex[i] <= cell_tex[(i > 0) ? i - 1 : 0];
          cell_dep[i] <= cell_dep[(i > 0) ? i - 1 : 0];
          cell_idx[i] <= cell_idx[(i > 0) ? i - 1 : 0];
        end else begin
          cell_tex[i] <= ins_tex;
          cell_dep[i] <= ins_dep;
          cell_idx[i] <= ins_idx;
        end
      end else if (cmd.emit && i < CAPACITY - 1) begin
        cell_tex[i] <= cell_tex[(i < CAPACITY - 1) ? i + 1 : i];
        cell_dep[i] <= cell_dep[(i < CAPACITY - 1) ? i + 1 : i];
        cell_idx[i] <= cell_idx[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cell_vld <= '0;
    end else if (ins_vld) begin
      cell_vld <= {cell_vld[CAPACITY-2:0], 1'b1};
    end else if (cmd.emit) begin
      cell_vld <= {1'b0, cell_vld[CAPACITY-1:1]};
    end
  end

  assign stat.emit_last = !cell_vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      first        <= 1'b1;
      offset       <= '0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.clear) begin
        first  <= 1'b1;
        offset <= '0;
      end else if (cmd.emit) begin
        first  <= 1'b0;
        offset <= offset + VERTS_PER_GLYPH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      prev_tex      <= cell_tex[0];
      glyph_index   <= cell_idx[0];
      glyph_texture <= TEX_PORT_W'(cell_tex[0]);
      vertex_offset <= offset;
      batch_start   <= first || (prev_tex != cell_tex[0]);
      batch_end     <= !cell_vld[1] || (cell_tex[1] != cell_tex[0]);
      run_last      <= !cell_vld[1];
    end
  end
endmodule
`default_nettype wire

### rtl/glyph_sort_and_batch_core.sv
// Top level of the glyph sort and batch unit.
//
// Use: glyph records (texture_id, depth_key) are transferred one per cycle by
// raising start while busy is low. Each record is written into the record
// store; once CAPACITY records are held, further records are dropped. The
// record that carries final_glyph is stored too (if there is room) and then
// the frame is sorted by sort_mode: none, ascending depth, descending depth
// or ascending texture, ties kept in arrival order.
// Sorting feeds the n stored records, one per cycle, from the store into an
// insertion-sort cell chain; a drain state then lets the last insertion
// settle. The chain then shifts out the n results, one per cycle. Each
// result is registered and shown for one cycle with result_valid high.
// busy stays high through the sort, drain and emit states, and the next
// record can be transferred in the cycle that shows the last result.
// Records load at one per cycle while busy is low.
// The receiver cannot stall, so every result must be taken as it appears.
// The user must write sort_mode through cfg_we and cfg_data only while the
// block is idle; the block itself does not enforce this. Reset clears the
// glyph count, the sort mode and the controller; the store keeps its contents.
`default_nettype none
module glyph_sort_and_batch_core import gsb_pkg::*; #(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int TEXTURE_BITS = TEXTURE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [MODE_W-1:0]         cfg_data,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [TEX_PORT_W-1:0]     texture_id,
  input  wire logic signed [DEPTH_W-1:0] depth_key,
  input  wire logic                      final_glyph,
  output logic                           result_valid,
  output logic [IDX_W-1:0]               glyph_index,
  output logic [TEX_PORT_W-1:0]          glyph_texture,
  output logic [OFFS_W-1:0]              vertex_offset,
  output logic                           batch_start,
  output logic                           batch_end,
  output logic                           run_last
);
  gsb_cmd_t  cmd;
  gsb_stat_t stat;

  // The controller sequences the load, sort and emit phases.
  gsb_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .final_glyph (final_glyph),
    .busy        (busy),
    .cmd         (cmd),
    .stat        (stat)
  );

  // The datapath holds the store, the sorting chain and the result registers.
  gsb_datapath #(.CAPACITY(CAPACITY), .TEXTURE_BITS(TEXTURE_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .texture_id    (texture_id),
    .depth_key     (depth_key),
    .cmd           (cmd),
    .stat          (stat),
    .result_valid  (result_valid),
    .glyph_index   (glyph_index),
    .glyph_texture (glyph_texture),
    .vertex_offset (vertex_offset),
    .batch_start   (batch_start),
    .batch_end     (batch_end),
    .run_last      (run_last)
  );
endmodule
`default_nettype wire

### test/glyph_sort_and_batch_core_tb.sv
// Testbench for the glyph sort and batch unit: predicted sorted frames checked against the block.
`default_nettype none
module glyph_sort_and_batch_core_tb;
  import gsb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One glyph record as offered on the input ports.
  typedef struct packed {
    logic [15:0]        tex;
    logic signed [15:0] depth;
    logic               fin;
  } glyph_rec_t;

  // One emitted glyph as the block should present it.
  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [15:0]       tex;
    logic [OFFS_W-1:0] offset;
    logic              bstart;
    logic              bend;
    logic              last;
  } emit_rec_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [MODE_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] texture_id = '0;
  logic signed [15:0] depth_key = '0;
  logic final_glyph = 1'b0;
  logic result_valid;
  logic [IDX_W-1:0] glyph_index;
  logic [15:0] glyph_texture;
  logic [OFFS_W-1:0] vertex_offset;
  logic batch_start, batch_end, run_last;

  glyph_sort_and_batch_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .texture_id(texture_id), .depth_key(depth_key),
    .final_glyph(final_glyph), .result_valid(result_valid),
    .glyph_index(glyph_index), .glyph_texture(glyph_texture),
    .vertex_offset(vertex_offset), .batch_start(batch_start),
    .batch_end(batch_end), .run_last(run_last)
  );

  always #6 clk = ~clk;

  glyph_rec_t pending_glyphs[$];
  emit_rec_t  expected_emits[$];
  int unsigned sender_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  // Predictor state: the frame as loaded so far and the current sort mode.
  sort_mode_t       pred_mode = MODE_NONE;
  logic [15:0]        frame_tex[64];
  logic signed [15:0] frame_depth[64];
  int                 frame_count = 0;

  // True when glyph a must strictly precede glyph b under the current mode.
  function automatic bit precedes(int a, int b);
    case (pred_mode)
      MODE_DEPTH_UP: return frame_depth[a] < frame_depth[b];
      MODE_DEPTH_DN: return frame_depth[a] > frame_depth[b];
      MODE_TEXTURE:  return frame_tex[a] < frame_tex[b];
      default:       return 1'b0;
    endcase
  endfunction

  // Loads one accepted glyph; on the final one, sorts the frame stably and
  // queues one expected emission per stored glyph with its run markers.
  task automatic load_glyph(glyph_rec_t g);
    int order[64];
    int cur, j;
    emit_rec_t e;
    if (frame_count < 64) begin
      frame_tex[frame_count] = g.tex;
      frame_depth[frame_count] = g.depth;
      frame_count++;
    end
    if (!g.fin) return;
    for (int i = 0; i < frame_count; i++) order[i] = i;
    // Insertion sort moves a glyph only past strictly later ones, so ties stay put.
    for (int i = 1; i < frame_count; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && precedes(cur, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int k = 0; k < frame_count; k++) begin
      e.index  = IDX_W'(order[k]);
      e.tex    = frame_tex[order[k]];
      e.offset = OFFS_W'(k * 6);
      e.bstart = (k == 0) || (frame_tex[order[k-1]] != e.tex);
      e.last   = (k == frame_count - 1);
      e.bend   = e.last || (frame_tex[order[k+1]] != e.tex);
      expected_emits.insert(expected_emits.size(), e);
    end
    frame_count = 0;
  endtask

  // Driver: presents the head of the queue at falling edges, holding start
  // high until a transfer happens, with random idle gaps between transfers.
  bit offered = 1'b0;
  bit took = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (took) begin
        void'(pending_glyphs.pop_front());
        offered = 1'b0;
        took = 1'b0;
      end
      if (!offered && pending_glyphs.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        texture_id  <= pending_glyphs[0].tex;
        depth_key   <= pending_glyphs[0].depth;
        final_glyph <= pending_glyphs[0].fin;
        offered = 1'b1;
      end
      start <= offered;
    end
  end

  // Monitor: predicts on every input transfer and checks every result strobe.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) begin
        took = 1'b1;
        load_glyph('{tex: texture_id, depth: depth_key, fin: final_glyph});
      end
      if (result_valid) begin
        if (expected_emits.size() == 0) begin
          $display("%0t: unexpected result index=%0d tex=%h", $time, glyph_index,
                   glyph_texture);
          error_count++;
        end else begin
          emit_rec_t want, got;
          want = expected_emits.pop_front();
          got = '{index: glyph_index, tex: glyph_texture, offset: vertex_offset,
                  bstart: batch_start, bend: batch_end, last: run_last};
          if (got.index != want.index)
            $display("%0t: glyph_index expected %0d got %0d", $time, want.index, got.index);
          if (got.tex != want.tex)
            $display("%0t: glyph_texture expected %h got %h", $time, want.tex, got.tex);
          if (got.offset != want.offset)
            $display("%0t: vertex_offset expected %0d got %0d", $time, want.offset,
                     got.offset);
          if (got.bstart != want.bstart)
            $display("%0t: batch_start expected %b got %b", $time, want.bstart, got.bstart);
          if (got.bend != want.bend)
            $display("%0t: batch_end expected %b got %b", $time, want.bend, got.bend);
          if (got.last != want.last)
            $display("%0t: run_last expected %b got %b", $time, want.last, got.last);
          if (got != want) error_count++;
        end
      end
      if ((start && !busy) || result_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a long stretch with no transfer at all means the block hung.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Queues one frame of n glyphs; kind picks how textures and depths are drawn:
  // fully at random, or from small sets so that runs and ties are common.
  task automatic queue_frame(int n, int kind);
    glyph_rec_t g;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: begin
          g.tex = 16'($urandom);
          g.depth = 16'($urandom);
        end
        1: begin
          g.tex = 16'($urandom_range(3));
          g.depth = $signed(16'($urandom_range(7))) - 16'sd4;
        end
        default: begin
          g.tex = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
          g.depth = ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
        end
      endcase
      g.fin = (i == n - 1);
      pending_glyphs.insert(pending_glyphs.size(), g);
    end
  endtask

  // Waits until every queued glyph is taken and every result has come back;
  // the block is idle again by then, and the task still lets the clock run on.
  task automatic wait_idle();
    wait (pending_glyphs.size() == 0 && !offered);
    wait (expected_emits.size() == 0);
    repeat (140) @(posedge clk);
  endtask

  // Writes the sort mode at a falling edge while the block is idle.
  task automatic write_mode(sort_mode_t m);
    @(negedge clk);
    cfg_data <= m;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    pred_mode = m;
  endtask

  initial begin
    int size_pick;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a single glyph frame, the field extremes in ascending depth, a
    // small frame per mode, and an overfull frame whose final glyph is dropped but still sorts.
    write_mode(MODE_DEPTH_UP);
    pending_glyphs.insert(pending_glyphs.size(), '{tex: 16'hFFFF, depth: 16'sh7FFF, fin: 1'b1});
    pending_glyphs.insert(pending_glyphs.size(), '{tex: 16'h0000, depth: 16'sh8000, fin: 1'b0});
    pending_glyphs.insert(pending_glyphs.size(), '{tex: 16'hFFFF, depth: 16'sh7FFF, fin: 1'b0});
    pending_glyphs.insert(pending_glyphs.size(), '{tex: 16'h0000, depth: 16'sh0000, fin: 1'b0});
    pending_glyphs.insert(pending_glyphs.size(), '{tex: 16'h5A5A, depth: 16'shFFFF, fin: 1'b0});
    pending_glyphs.insert(pending_glyphs.size(), '{tex: 16'hA5A5, depth: 16'sh0001, fin: 1'b1});
    wait_idle();
    for (int m = 0; m < 4; m++) begin
      write_mode(sort_mode_t'(m));
      queue_frame(6, 1);
      wait_idle();
    end
    queue_frame(66, 2);
    wait_idle();

    // Random frames in phases of sender idling; most frames are small.
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = (phase == 1) ? 83 : (phase == 3) ? 22 : 0;
      write_mode(sort_mode_t'(phase == 0 ? 3 : $urandom_range(3)));
      for (int f = 0; f < 8; f++) begin
        size_pick = $urandom_range(99);
        queue_frame(size_pick < 8 ? $urandom_range(70, 60) : $urandom_range(12, 1),
                    $urandom_range(2));
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
rtl/gsb_pkg.sv
rtl/gsb_ctrl.sv
rtl/gsb_datapath.sv
rtl/glyph_sort_and_batch_core.sv
test/glyph_sort_and_batch_core_tb.sv
